@@ sv/cdst_pkg.sv @@
// ----------------------------------------------------------------------------
// cdst_pkg: shared constants and helpers for the soft dot stamp canvas
// Field widths, root unit sizing, request kinds and the intensity falloff.
// ----------------------------------------------------------------------------
package cdst_pkg;

  // default geometry
  localparam int GRID_SIZE_DEF       = 28;
  localparam int COORD_FRAC_BITS_DEF = 4;

  // fixed field widths
  localparam int POS_W = 9;
  localparam int IDX_W = 10;
  localparam int PIX_W = 8;

  // request kinds
  localparam logic KIND_STAMP = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // root unit: radicand is squared distance in units of 2^-16, root in Q.8
  localparam int SQ_IN_W   = 18;
  localparam int SQ_OUT_W  = 9;
  localparam int SQ_STEPS  = 9;
  localparam int DIST_FRAC = 8;

  // falloff: 2.0 in Q.8 distance units, full intensity code
  localparam int DIST_TWO = 512;
  localparam int PIX_FULL = 255;

  // rounded full * (1 - q/2) with q in Q.8
  function automatic logic [PIX_W-1:0] dot_value(input logic [SQ_OUT_W-1:0] q);
    logic [SQ_OUT_W:0] left;
    logic [SQ_IN_W-1:0] scaled;
    logic [SQ_IN_W-1:0] rounded;
    left    = (SQ_OUT_W+1)'(DIST_TWO) - {1'b0, q};
    scaled  = SQ_IN_W'(left) * SQ_IN_W'(PIX_FULL);
    rounded = (scaled + SQ_IN_W'(DIST_TWO / 2)) >> (DIST_FRAC + 1);
    return rounded[PIX_W-1:0];
  endfunction

endpackage

@@ sv/cdst_sqrt.sv @@
// ----------------------------------------------------------------------------
// cdst_sqrt: iterative integer square root
// One result bit per cycle with a single compare and subtract.
// ----------------------------------------------------------------------------
module cdst_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [cdst_pkg::SQ_IN_W-1:0]      radicand,
  output logic [cdst_pkg::SQ_OUT_W-1:0]     root,
  output logic                              done
);

  localparam int CW = $clog2(cdst_pkg::SQ_STEPS + 1);

  logic [cdst_pkg::SQ_IN_W-1:0] rem;
  logic [cdst_pkg::SQ_IN_W-1:0] acc;
  logic [cdst_pkg::SQ_IN_W-1:0] probe;
  logic [CW-1:0]                cnt;
  logic                         active;
  logic [cdst_pkg::SQ_IN_W:0]   trial;

  // trial subtrahend for this step
  assign trial = {1'b0, acc} + {1'b0, probe};
  assign root  = acc[cdst_pkg::SQ_OUT_W-1:0];

  // digit recurrence
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem    <= radicand;
        acc    <= '0;
        probe  <= cdst_pkg::SQ_IN_W'(1) << (cdst_pkg::SQ_IN_W - 2);
        cnt    <= CW'(cdst_pkg::SQ_STEPS);
        active <= 1'b1;
      end else if (active) begin
        if ({1'b0, rem} >= trial) begin
          rem <= rem - trial[cdst_pkg::SQ_IN_W-1:0];
          acc <= (acc >> 1) + probe;
        end else begin
          acc <= acc >> 1;
        end
        probe <= probe >> 2;
        cnt   <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/cdst_mem.sv @@
// ----------------------------------------------------------------------------
// cdst_mem: canvas storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cdst_mem #(
  parameter  int DEPTH = cdst_pkg::GRID_SIZE_DEF * cdst_pkg::GRID_SIZE_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [cdst_pkg::PIX_W-1:0]    wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [cdst_pkg::PIX_W-1:0]    rdata
);

  logic [cdst_pkg::PIX_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, always enabled
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/canvas_soft_dot_stamp_unit.sv @@
// ----------------------------------------------------------------------------
// canvas_soft_dot_stamp_unit: grayscale canvas with soft dot stamping
//
//   channel   handshake       payload
//   request   start / busy    kind, row_pos, col_pos, pixel_index
//   result    done (strobe)   pixel_value
//
// A read's result strobes for one cycle, in the same cycle that busy drops.
// A stamp walks a 4x4 window one pixel at a time: a skipped pixel passes
// through the setup and two squaring states, a touched one also through
// the kick, root wait and write states, using the shared squarer and the
// bit-per-cycle root unit; at most 14 window pixels fall inside the disc.
// After reset a clearing pass writes zero to all GRID_SIZE*GRID_SIZE cells
// (784 by default) with busy high. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module canvas_soft_dot_stamp_unit #(
  parameter int GRID_SIZE       = cdst_pkg::GRID_SIZE_DEF,
  parameter int COORD_FRAC_BITS = cdst_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [cdst_pkg::POS_W-1:0]    row_pos,
  input  logic [cdst_pkg::POS_W-1:0]    col_pos,
  input  logic [cdst_pkg::IDX_W-1:0]    pixel_index,
  output logic                          done,
  output logic [cdst_pkg::PIX_W-1:0]    pixel_value
);

  localparam int F      = COORD_FRAC_BITS;
  localparam int U      = 1 << F;
  localparam int DW     = F + 3;
  localparam int D2W    = 2 * F + 4;
  localparam int IPW    = cdst_pkg::POS_W - F;
  localparam int GW     = $clog2(GRID_SIZE + 1);
  localparam int IW     = ((IPW > GW) ? IPW : GW) + 2;
  localparam int CELLS  = GRID_SIZE * GRID_SIZE;
  localparam int AW     = $clog2(CELLS);
  localparam int IXW    = ((AW > cdst_pkg::IDX_W) ? AW : cdst_pkg::IDX_W) + 1;
  localparam int RSHIFT = 2 * cdst_pkg::DIST_FRAC - 2 * F;
  localparam logic [D2W-1:0] LIMIT  = D2W'(4) << (2 * F);
  localparam logic [AW-1:0]  GRID_A = AW'(GRID_SIZE);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_SETUP, S_SQR, S_SQC, S_KICK, S_ROOT, S_WRITE
  } state_t;

  state_t                          state;
  logic [AW-1:0]                   clr_addr;
  logic [IPW-1:0]                  ri, ci;
  logic [F-1:0]                    rf, cf;
  logic [1:0]                      ro, co;
  logic signed [DW-1:0]            dr, dc;
  logic                            in_grid;
  logic [AW-1:0]                   pix_addr;
  logic [D2W-1:0]                  d2;
  logic                            rd_ok;

  logic signed [IW-1:0]            r_next, c_next;
  logic signed [DW-1:0]            dr_next, dc_next;
  logic                            grid_next;
  logic signed [DW-1:0]            mul_a;
  logic signed [2*DW-1:0]          prod;
  logic [D2W-1:0]                  d2_sum;
  logic [IXW-1:0]                  idx_x;
  logic [cdst_pkg::PIX_W-1:0]      rdata;
  logic [cdst_pkg::PIX_W-1:0]      new_val;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [cdst_pkg::PIX_W-1:0]      mem_wdata;
  logic [AW-1:0]                   mem_raddr;
  logic                            sq_start;
  logic [cdst_pkg::SQ_IN_W-1:0]    sq_in;
  logic [cdst_pkg::SQ_OUT_W-1:0]   sq_root;
  logic                            sq_done;
  logic                            accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign idx_x  = IXW'(pixel_index);

  // window pixel position and offsets from the dot centre
  assign r_next    = $signed(IW'(ri)) - $signed(IW'(1)) + $signed(IW'(ro));
  assign c_next    = $signed(IW'(ci)) - $signed(IW'(1)) + $signed(IW'(co));
  assign dr_next   = $signed({1'b0, ro, {F{1'b0}}}) - $signed(DW'(U)) - $signed(DW'(rf));
  assign dc_next   = $signed({1'b0, co, {F{1'b0}}}) - $signed(DW'(U)) - $signed(DW'(cf));
  assign grid_next = (r_next >= 0) && (r_next < $signed(IW'(GRID_SIZE))) &&
                     (c_next >= 0) && (c_next < $signed(IW'(GRID_SIZE)));

  // shared squarer
  assign mul_a  = (state == S_SQR) ? dr : dc;
  assign prod   = mul_a * mul_a;
  assign d2_sum = d2 + D2W'($unsigned(prod));

  // root unit feed
  assign sq_start = (state == S_KICK);
  assign sq_in    = cdst_pkg::SQ_IN_W'(d2) << RSHIFT;

  // falloff and memory ports
  assign new_val   = cdst_pkg::dot_value(sq_root);
  assign mem_we    = (state == S_CLEAR) || ((state == S_WRITE) && (new_val > rdata));
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : pix_addr;
  assign mem_wdata = (state == S_CLEAR) ? '0 : new_val;
  assign mem_raddr = (state == S_IDLE) ? idx_x[AW-1:0] : pix_addr;

  cdst_mem #(
    .DEPTH (CELLS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  cdst_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_in),
    .root     (sq_root),
    .done     (sq_done)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (kind == cdst_pkg::KIND_READ) begin
              rd_ok <= idx_x < IXW'(CELLS);
              state <= S_READ;
            end else begin
              ri    <= row_pos[cdst_pkg::POS_W-1:F];
              rf    <= row_pos[F-1:0];
              ci    <= col_pos[cdst_pkg::POS_W-1:F];
              cf    <= col_pos[F-1:0];
              ro    <= 2'd0;
              co    <= 2'd0;
              state <= S_SETUP;
            end
          end
        end
        S_READ: begin
          pixel_value <= rd_ok ? rdata : '0;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        S_SETUP: begin
          dr       <= dr_next;
          dc       <= dc_next;
          in_grid  <= grid_next;
          pix_addr <= AW'($unsigned(r_next)) * GRID_A + AW'($unsigned(c_next));
          state    <= S_SQR;
        end
        S_SQR: begin
          d2    <= D2W'($unsigned(prod));
          state <= S_SQC;
        end
        S_SQC: begin
          d2 <= d2_sum;
          if (in_grid && (d2_sum < LIMIT)) begin
            state <= S_KICK;
          end else begin
            // outside grid or disc: move to next window pixel
            co <= co + 2'd1;
            if (co == 2'd3) begin
              ro <= ro + 2'd1;
            end
            state <= ((ro == 2'd3) && (co == 2'd3)) ? S_IDLE : S_SETUP;
          end
        end
        S_KICK: begin
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_done) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          co <= co + 2'd1;
          if (co == 2'd3) begin
            ro <= ro + 2'd1;
          end
          state <= ((ro == 2'd3) && (co == 2'd3)) ? S_IDLE : S_SETUP;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a result only follows a read request
  a_done_after_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_READ)
    else $error("result strobe without a read");

  // the root unit finishes only while the sequencer waits on it
  a_root_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == S_ROOT)
    else $error("root unit finished outside its wait state");

  // an accepted request makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request accepted but block not busy");
`endif

endmodule
